// ===== rtl/disk_body_physics_step_core_defines.svh =====
// ----------------------------------------------------------------------------
// disk body physics step core: assertion macros
// shared clocked assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef DISK_BODY_PHYSICS_STEP_CORE_DEFINES_SVH
`define DISK_BODY_PHYSICS_STEP_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define DBPS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define DBPS_ASSERT(lbl, prop, msg) `DBPS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/dbps_pkg.sv =====
// ----------------------------------------------------------------------------
// dbps_pkg
// types, constants, microprogram and arithmetic helpers of the disk body core
// ----------------------------------------------------------------------------
package dbps_pkg;

  localparam int NUM_BODIES_DEF = 8;

  // item kinds
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_COLLIDE = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_FIELD_W  = 2'd0;
  localparam logic [1:0] CFG_FIELD_H  = 2'd1;
  localparam logic [1:0] CFG_FRICTION = 2'd2;
  localparam logic [1:0] CFG_REST     = 2'd3;

  localparam logic [11:0] FIELD_W_RST  = 12'd800;
  localparam logic [11:0] FIELD_H_RST  = 12'd600;
  localparam logic [15:0] FRICTION_RST = 16'd64225;
  localparam logic [14:0] REST_RST     = 15'd64;

  // fixed-point gains, q0.16
  localparam logic signed [21:0] K_WALL_SPIN = 22'sd20972;
  localparam logic signed [21:0] K_ANG_FRIC  = 22'sd64881;
  localparam logic signed [21:0] K_DAMP      = 22'sd52429;
  localparam logic signed [21:0] K_HIT_SPIN  = 22'sd5243;
  localparam logic signed [15:0] K_SPIN_SNAP = 16'sd41;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 112;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] sp;
    logic        [15:0] ang;
    logic        [15:0] rad;
  } body_t;

  typedef enum logic [5:0] {
    OP_LOAD, OP_RD_A, OP_LD_A, OP_LD_B,
    OP_T_LEFT, OP_T_RIGHT, OP_T_TOP, OP_T_BOT,
    OP_T_FX, OP_T_FY, OP_T_FS, OP_T_SNAP, OP_T_INT,
    OP_C_D, OP_C_SQX, OP_C_SQY, OP_C_CHK0, OP_C_SQRT, OP_C_CMP,
    OP_C_DIVX, OP_C_DIVY, OP_C_P1, OP_C_V1, OP_C_P2, OP_C_V2,
    OP_C_EA, OP_C_EB, OP_C_AVX, OP_C_AVY, OP_C_BVX, OP_C_BVY,
    OP_C_ASP, OP_C_BSP, OP_C_PX, OP_C_PY, OP_C_POS,
    OP_WR_A, OP_WR_B, OP_END
  } op_e;

  localparam int PROG_LEN = 44;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] PC_LOAD = PC_W'(0);
  localparam logic [PC_W-1:0] PC_TICK = PC_W'(2);
  localparam logic [PC_W-1:0] PC_COLL = PC_W'(15);

  // step sequences of the three actions
  localparam op_e PROG [PROG_LEN] = '{
    OP_LOAD, OP_END,
    OP_RD_A, OP_LD_A, OP_T_LEFT, OP_T_RIGHT, OP_T_TOP, OP_T_BOT,
    OP_T_FX, OP_T_FY, OP_T_FS, OP_T_SNAP, OP_T_INT, OP_WR_A, OP_END,
    OP_RD_A, OP_LD_A, OP_LD_B, OP_C_D, OP_C_SQX, OP_C_SQY, OP_C_CHK0,
    OP_C_SQRT, OP_C_CMP, OP_C_DIVX, OP_C_DIVY, OP_C_P1, OP_C_V1,
    OP_C_P2, OP_C_V2, OP_C_EA, OP_C_EB, OP_C_AVX, OP_C_AVY, OP_C_BVX,
    OP_C_BVY, OP_C_ASP, OP_C_BSP, OP_C_PX, OP_C_PY, OP_C_POS,
    OP_WR_A, OP_WR_B, OP_END
  };

  typedef struct packed {
    op_e  op;
    logic step;
    logic accept;
    logic emit_a;
    logic emit_b;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic iter_busy;
    logic iter_done;
    logic d2_zero;
    logic too_far;
    logic out_free;
  } st_t;

  // round half up, then arithmetic shift
  function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
                                                 input int unsigned s);
    logic signed [47:0] half;
    half = 48'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
    logic signed [19:0] r;
    if (v > 48'sd524287) r = 20'sh7ffff;
    else if (v < -48'sd524288) r = 20'sh80000;
    else r = v[19:0];
    return r;
  endfunction

endpackage

// ===== rtl/dbps_iter.sv =====
// ----------------------------------------------------------------------------
// dbps_iter
// shared bit-serial unit: integer square root or unsigned division
// ----------------------------------------------------------------------------
module dbps_iter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [43:0] rad_i,
  input  logic [32:0] num_i,
  input  logic [16:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [21:0] res_o
);

  logic        busy_q, busy_d, done_q, done_d, sqrt_q, sqrt_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [43:0] src_q, src_d;
  logic [21:0] res_q, res_d;
  logic [16:0] den_q, den_d;
  logic [25:0] sq_r2, sq_trial;
  logic [17:0] dv_r2;

  // one root bit or one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    src_d  = src_q;
    res_d  = res_q;
    den_d  = den_q;
    sq_r2    = {rem_q, src_q[43:42]};
    sq_trial = {2'b00, res_q, 2'b01};
    dv_r2    = {rem_q[16:0], src_q[43]};
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      res_d  = '0;
      den_d  = den_i;
      if (sqrt_i) begin
        rem_d = '0;
        src_d = rad_i;
        cnt_d = 5'd22;
      end else begin
        rem_d = {8'b0, num_i[32:17]};
        src_d = {num_i[16:0], 27'b0};
        cnt_d = 5'd17;
      end
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (sq_r2 >= sq_trial) begin
          rem_d = 24'(sq_r2 - sq_trial);
          res_d = {res_q[20:0], 1'b1};
        end else begin
          rem_d = 24'(sq_r2);
          res_d = {res_q[20:0], 1'b0};
        end
        src_d = {src_q[41:0], 2'b00};
      end else begin
        if (dv_r2 >= {1'b0, den_q}) begin
          rem_d = 24'(dv_r2 - {1'b0, den_q});
          res_d = {res_q[20:0], 1'b1};
        end else begin
          rem_d = 24'(dv_r2);
          res_d = {res_q[20:0], 1'b0};
        end
        src_d = {src_q[42:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    rem_q  <= rem_d;
    src_q  <= src_d;
    res_q  <= res_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/dbps_datapath.sv =====
// ----------------------------------------------------------------------------
// dbps_datapath
// body table, working registers, shared multiplier and output register
// ----------------------------------------------------------------------------
module dbps_datapath #(
  parameter int NUM_BODIES = dbps_pkg::NUM_BODIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dbps_pkg::cmd_t                  cmd_i,
  output dbps_pkg::st_t                   st_o,
  input  logic [dbps_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dbps_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_last_o
);
  import dbps_pkg::*;

  localparam int IDX_W = $clog2(NUM_BODIES);

  // configuration
  logic [11:0] fw_q, fh_q;
  logic [15:0] fg_q;
  logic [14:0] rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FIELD_W_RST;
      fh_q   <= FIELD_H_RST;
      fg_q   <= FRICTION_RST;
      rest_q <= REST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIELD_W:  fw_q   <= cfg_wdata_i[11:0];
        CFG_FIELD_H:  fh_q   <= cfg_wdata_i[11:0];
        CFG_FRICTION: fg_q   <= cfg_wdata_i;
        CFG_REST:     rest_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [2:0] ia_q, ib_q;
  body_t      ld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ia_q     <= in_data_i[2:0];
      ib_q     <= in_data_i[5:3];
      ld_q.x   <= in_data_i[25:6];
      ld_q.y   <= in_data_i[45:26];
      ld_q.vx  <= in_data_i[61:46];
      ld_q.vy  <= in_data_i[77:62];
      ld_q.sp  <= '0;
      ld_q.ang <= '0;
      ld_q.rad <= in_data_i[93:78];
    end
  end

  logic [IDX_W-1:0] a_addr, b_addr;
  assign a_addr = IDX_W'(ia_q);
  assign b_addr = IDX_W'(ib_q);

  // body table with valid bits, registered read
  body_t            mem [NUM_BODIES];
  logic [NUM_BODIES-1:0] valid_q;
  body_t            rd_q, rd_body;
  logic             rdv_q, we;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  body_t            wr_data;
  body_t            a_q, a_d, b_q, b_d;

  assign rd_addr = (cmd_i.op == OP_LD_A) ? b_addr : a_addr;
  assign rd_body = rdv_q ? rd_q : '0;

  always_comb begin
    we      = 1'b0;
    wr_addr = a_addr;
    wr_data = a_q;
    if (cmd_i.step) begin
      if (cmd_i.op == OP_LOAD) begin
        we      = 1'b1;
        wr_data = ld_q;
      end else if (cmd_i.op == OP_WR_A) begin
        we = 1'b1;
      end else if (cmd_i.op == OP_WR_B) begin
        we      = 1'b1;
        wr_addr = b_addr;
        wr_data = b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q  <= mem[rd_addr];
    rdv_q <= valid_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (we) valid_q[wr_addr] <= 1'b1;
  end

  // shared iterative unit
  logic        it_start, it_busy, it_done;
  logic [21:0] it_res;
  logic signed [20:0] dx_q, dx_d, dy_q, dy_d, dx_abs, dy_abs;
  logic [41:0] d2_q, d2_d;
  logic [21:0] dist_q, dist_d;
  logic [32:0] it_num;

  assign dx_abs = dx_q[20] ? -dx_q : dx_q;
  assign dy_abs = dy_q[20] ? -dy_q : dy_q;
  assign it_start = cmd_i.step && (cmd_i.op == OP_C_SQRT || cmd_i.op == OP_C_DIVX ||
                                   cmd_i.op == OP_C_DIVY);
  assign it_num = (cmd_i.op == OP_C_DIVY) ? {dy_abs[16:0], 16'b0} : {dx_abs[16:0], 16'b0};

  dbps_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(it_start),
    .sqrt_i (cmd_i.op == OP_C_SQRT),
    .rad_i  (44'(d2_q)),
    .num_i  (it_num),
    .den_i  (dist_q[16:0]),
    .busy_o (it_busy),
    .done_o (it_done),
    .res_o  (it_res)
  );

  // working values
  logic signed [17:0] ux_q, ux_d, uy_q, uy_d, v1_q, v1_d, v2_q, v2_d, ov, quo;
  logic signed [18:0] ea_q, ea_d, eb_q, eb_d, px_q, px_d, py_q, py_d, da, nda;
  logic signed [43:0] pr_q, pr_d, prod;
  logic signed [47:0] pw, rnd16, ra_s, rb_s, wq_s, hq_s;
  logic signed [21:0] mul_a, mul_b;
  logic signed [15:0] rs_s, fs_t;
  logic [16:0] sum;
  logic        hit_q, hit_d;

  assign sum  = 17'(a_q.rad) + 17'(b_q.rad);
  assign ov   = $signed({1'b0, sum}) - $signed({1'b0, dist_q[16:0]});
  assign da   = 19'(v2_q) - 19'(v1_q);
  assign nda  = -da;
  assign ra_s = 48'($signed({1'b0, a_q.rad}));
  assign rb_s = 48'($signed({1'b0, b_q.rad}));
  assign wq_s = 48'($signed({1'b0, fw_q, 8'b0}));
  assign hq_s = 48'($signed({1'b0, fh_q, 8'b0}));
  assign rs_s = $signed({1'b0, rest_q});
  assign quo  = $signed({1'b0, it_res[16:0]});

  // operand select of the single multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_T_LEFT, OP_T_RIGHT: begin mul_a = 22'(a_q.vy); mul_b = K_WALL_SPIN; end
      OP_T_TOP, OP_T_BOT:    begin mul_a = 22'(a_q.vx); mul_b = K_WALL_SPIN; end
      OP_T_FX: begin mul_a = 22'(a_q.vx); mul_b = {6'b0, fg_q}; end
      OP_T_FY: begin mul_a = 22'(a_q.vy); mul_b = {6'b0, fg_q}; end
      OP_T_FS: begin mul_a = 22'(a_q.sp); mul_b = K_ANG_FRIC; end
      OP_C_SQX: begin mul_a = 22'(dx_q); mul_b = 22'(dx_q); end
      OP_C_SQY: begin mul_a = 22'(dy_q); mul_b = 22'(dy_q); end
      OP_C_P1: begin mul_a = 22'(a_q.vx); mul_b = 22'(ux_q); end
      OP_C_V1: begin mul_a = 22'(a_q.vy); mul_b = 22'(uy_q); end
      OP_C_P2: begin mul_a = 22'(b_q.vx); mul_b = 22'(ux_q); end
      OP_C_V2: begin mul_a = 22'(b_q.vy); mul_b = 22'(uy_q); end
      OP_C_EA: begin mul_a = 22'(da); mul_b = K_DAMP; end
      OP_C_EB: begin mul_a = 22'(nda); mul_b = K_DAMP; end
      OP_C_AVX: begin mul_a = 22'(ea_q); mul_b = 22'(ux_q); end
      OP_C_AVY: begin mul_a = 22'(ea_q); mul_b = 22'(uy_q); end
      OP_C_BVX: begin mul_a = 22'(eb_q); mul_b = 22'(ux_q); end
      OP_C_BVY: begin mul_a = 22'(eb_q); mul_b = 22'(uy_q); end
      OP_C_ASP: begin mul_a = 22'(da); mul_b = K_HIT_SPIN; end
      OP_C_BSP: begin mul_a = 22'(nda); mul_b = K_HIT_SPIN; end
      OP_C_PX: begin mul_a = 22'(ov); mul_b = 22'(ux_q); end
      OP_C_PY: begin mul_a = 22'(ov); mul_b = 22'(uy_q); end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign pw    = 48'(prod);
  assign rnd16 = rnd_shr(pw, 16);
  assign fs_t  = sat16(rnd16);

  // step execution
  always_comb begin
    a_d = a_q;  b_d = b_q;  dx_d = dx_q; dy_d = dy_q; d2_d = d2_q;
    dist_d = dist_q; ux_d = ux_q; uy_d = uy_q; pr_d = pr_q;
    v1_d = v1_q; v2_d = v2_q; ea_d = ea_q; eb_d = eb_q;
    px_d = px_q; py_d = py_q; hit_d = hit_q;
    if (cmd_i.accept) hit_d = 1'b0;
    if (cmd_i.step) begin
      unique case (cmd_i.op)
        OP_LOAD: a_d = ld_q;
        OP_LD_A: a_d = rd_body;
        OP_LD_B: b_d = rd_body;
        // walls in order left, right, top, bottom
        OP_T_LEFT: if (48'(a_q.x) - ra_s < 48'sd0) begin
          a_d.x  = 20'(a_q.rad);
          a_d.vx = sat16(-48'(a_q.vx));
          a_d.sp = sat16(48'(a_q.sp) + rnd16);
          hit_d  = 1'b1;
        end
        OP_T_RIGHT: if (48'(a_q.x) + ra_s > wq_s) begin
          a_d.x  = sat20(wq_s - ra_s);
          a_d.vx = sat16(-48'(a_q.vx));
          a_d.sp = sat16(48'(a_q.sp) - rnd16);
          hit_d  = 1'b1;
        end
        OP_T_TOP: if (48'(a_q.y) - ra_s < 48'sd0) begin
          a_d.y  = 20'(a_q.rad);
          a_d.vy = sat16(-48'(a_q.vy));
          a_d.sp = sat16(48'(a_q.sp) - rnd16);
          hit_d  = 1'b1;
        end
        OP_T_BOT: if (48'(a_q.y) + ra_s > hq_s) begin
          a_d.y  = sat20(hq_s - ra_s);
          a_d.vy = sat16(-48'(a_q.vy));
          a_d.sp = sat16(48'(a_q.sp) + rnd16);
          hit_d  = 1'b1;
        end
        // friction and snap to rest
        OP_T_FX: a_d.vx = sat16(rnd16);
        OP_T_FY: a_d.vy = sat16(rnd16);
        OP_T_FS: a_d.sp = (fs_t > -K_SPIN_SNAP && fs_t < K_SPIN_SNAP) ? '0 : fs_t;
        OP_T_SNAP: if (a_q.vx > -rs_s && a_q.vx < rs_s &&
                       a_q.vy > -rs_s && a_q.vy < rs_s) begin
          a_d.vx = '0;
          a_d.vy = '0;
        end
        OP_T_INT: begin
          a_d.x   = sat20(48'(a_q.x) + 48'(a_q.vx));
          a_d.y   = sat20(48'(a_q.y) + 48'(a_q.vy));
          a_d.ang = a_q.ang + 16'(a_q.sp);
        end
        // pair geometry
        OP_C_D: begin
          dx_d = 21'(a_q.x) - 21'(b_q.x);
          dy_d = 21'(a_q.y) - 21'(b_q.y);
        end
        OP_C_SQX: d2_d = 42'(prod);
        OP_C_SQY: d2_d = d2_q + 42'(prod);
        OP_C_P1, OP_C_P2: pr_d = prod;
        OP_C_V1: v1_d = 18'(rnd_shr(48'(pr_q) + pw, 16));
        OP_C_V2: v2_d = 18'(rnd_shr(48'(pr_q) + pw, 16));
        OP_C_EA: ea_d = 19'(rnd16);
        OP_C_EB: eb_d = 19'(rnd16);
        OP_C_AVX: a_d.vx = sat16(48'(a_q.vx) + rnd16);
        OP_C_AVY: a_d.vy = sat16(48'(a_q.vy) + rnd16);
        OP_C_BVX: b_d.vx = sat16(48'(b_q.vx) + rnd16);
        OP_C_BVY: b_d.vy = sat16(48'(b_q.vy) + rnd16);
        OP_C_ASP: a_d.sp = sat16(48'(a_q.sp) - rnd16);
        OP_C_BSP: b_d.sp = sat16(48'(b_q.sp) + rnd16);
        OP_C_PX: px_d = 19'(rnd_shr(pw, 17));
        OP_C_PY: py_d = 19'(rnd_shr(pw, 17));
        // push apart with the one-pixel offset
        OP_C_POS: begin
          a_d.x = sat20(48'(a_q.x) + 48'(px_q) + 48'sd256);
          a_d.y = sat20(48'(a_q.y) + 48'(py_q) + 48'sd256);
          b_d.x = sat20(48'(b_q.x) - 48'(px_q) + 48'sd256);
          b_d.y = sat20(48'(b_q.y) - 48'(py_q) + 48'sd256);
          hit_d = 1'b1;
        end
        default: ;
      endcase
    end
    // results of the shared unit
    if (it_done) begin
      if (cmd_i.op == OP_C_SQRT) dist_d = it_res;
      else if (cmd_i.op == OP_C_DIVX) ux_d = dx_q[20] ? -quo : quo;
      else if (cmd_i.op == OP_C_DIVY) uy_d = dy_q[20] ? -quo : quo;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;  dx_q <= dx_d; dy_q <= dy_d; d2_q <= d2_d;
    dist_q <= dist_d; ux_q <= ux_d; uy_q <= uy_d; pr_q <= pr_d;
    v1_q <= v1_d; v2_q <= v2_d; ea_q <= ea_d; eb_q <= eb_d;
    px_q <= px_d; py_q <= py_d; hit_q <= hit_d;
  end

  // output register
  logic  out_valid_q;
  logic  out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  body_t em;
  logic [2:0] em_idx;

  assign em     = cmd_i.emit_b ? b_q : a_q;
  assign em_idx = cmd_i.emit_b ? ib_q : ia_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit_a || cmd_i.emit_b) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_a || cmd_i.emit_b) begin
      out_data_q <= {4'b0, hit_q, em.ang, em.sp, em.vy, em.vx, em.y, em.x, em_idx};
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign st_o.iter_busy = it_busy;
  assign st_o.iter_done = it_done;
  assign st_o.d2_zero   = (d2_q == '0);
  assign st_o.too_far   = (dist_q >= 22'(sum));
  assign st_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/dbps_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbps_ctrl
// sequencer: decodes items, steps the microprogram, issues result words
// ----------------------------------------------------------------------------
`include "disk_body_physics_step_core_defines.svh"

module dbps_ctrl #(
  parameter int NUM_BODIES = dbps_pkg::NUM_BODIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     in_act_i,
  input  logic [2:0]     in_a_i,
  input  logic [2:0]     in_b_i,
  input  dbps_pkg::st_t  st_i,
  output dbps_pkg::cmd_t cmd_o
);
  import dbps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RUN    = 5'b00010,
    S_WAIT   = 5'b00100,
    S_EMIT_A = 5'b01000,
    S_EMIT_B = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            pair_q, pair_d;
  logic            acc, a_ok, b_ok, is_iter;
  op_e             op;

  assign op      = PROG[pc_q];
  assign is_iter = (op == OP_C_SQRT) || (op == OP_C_DIVX) || (op == OP_C_DIVY);
  assign a_ok    = 32'(in_a_i) < NUM_BODIES;
  assign b_ok    = 32'(in_b_i) < NUM_BODIES;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    pair_d  = pair_q;
    unique case (state_q)
      S_IDLE: if (acc) begin
        priority if (in_act_i == ACT_LOAD && a_ok) begin
          pc_d = PC_LOAD; pair_d = 1'b0; state_d = S_RUN;
        end else if (in_act_i == ACT_TICK && a_ok) begin
          pc_d = PC_TICK; pair_d = 1'b0; state_d = S_RUN;
        end else if (in_act_i == ACT_COLLIDE && a_ok && b_ok) begin
          pc_d = PC_COLL; pair_d = 1'b1; state_d = S_RUN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (is_iter) state_d = S_WAIT;
        else if ((op == OP_C_CHK0 && st_i.d2_zero) || (op == OP_C_CMP && st_i.too_far) ||
                 op == OP_END) state_d = S_EMIT_A;
        else pc_d = pc_q + 1'b1;
      end
      S_WAIT: if (st_i.iter_done) begin
        pc_d    = pc_q + 1'b1;
        state_d = S_RUN;
      end
      S_EMIT_A: if (st_i.out_free) state_d = pair_q ? S_EMIT_B : S_IDLE;
      S_EMIT_B: if (st_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      pair_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pair_q  <= pair_d;
    end
  end

  // commands to the datapath
  assign cmd_o.op     = op;
  assign cmd_o.step   = (state_q == S_RUN);
  assign cmd_o.accept = acc;
  assign cmd_o.emit_a = (state_q == S_EMIT_A) && st_i.out_free;
  assign cmd_o.emit_b = (state_q == S_EMIT_B) && st_i.out_free;
  assign cmd_o.last   = (state_q == S_EMIT_B) || !pair_q;

  // checks
  `DBPS_ASSERT(a_wait_work, (state_q == S_WAIT) |-> (st_i.iter_busy || st_i.iter_done), "wait without work")
  `DBPS_ASSERT(a_iter_start, (state_q == S_RUN && is_iter) |=> st_i.iter_busy, "unit not started")
  `DBPS_ASSERT(a_second_pair, (state_q == S_EMIT_B) |-> pair_q, "second word without pair")

endmodule

// ===== rtl/disk_body_physics_step_core.sv =====
// ----------------------------------------------------------------------------
// disk_body_physics_step_core
// table of disk bodies with load, tick and pairwise collision actions
// ----------------------------------------------------------------------------
// One item is handled at a time. The block takes a new word only while the
// sequencer is idle. Load and tick steps run one step per cycle, with one
// shared multiplier. In a collision of overlapping bodies the shared
// bit-serial unit runs 22 iterations for the distance square root and 17 for
// each of the two unit-vector divisions, and the sequencer waits on each run;
// the rest is 26 single steps. A pair at zero distance ends at the zero check
// and a pair that does not touch ends at the distance compare. Each load or
// tick gives one result word, each collision two. A result cycle waits while
// the output register is full and not being read. The output register lets
// the next item start while the last word waits. Item indexes at or above
// NUM_BODIES that the action uses, and action 3, are dropped with no result.
module disk_body_physics_step_core #(
  parameter int NUM_BODIES = dbps_pkg::NUM_BODIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_index, second_index, load_x, load_y, load_vx, load_vy, load_radius
  input  logic [dbps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // body_index, pos_x, pos_y, vel_x, vel_y, spin, heading, hit
  output logic [dbps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i
);
  import dbps_pkg::*;

  cmd_t cmd;
  st_t  st;

  dbps_ctrl #(.NUM_BODIES(NUM_BODIES)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_act_i  (s_axis_tuser),
    .in_a_i    (s_axis_tdata[2:0]),
    .in_b_i    (s_axis_tdata[5:3]),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  dbps_datapath #(.NUM_BODIES(NUM_BODIES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
